// ===== hw/rtl/hcbp_pkg.sv =====
package hcbp_pkg;

  localparam int SYMBOL_COUNT_DEF    = 128;
  localparam int MAX_CODE_LENGTH_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int SYM_W   = 7;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int VBITS_W = 4;
  localparam int TOTAL_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  // one encode or flush handed from the table stage to the packer
  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } item_t;

endpackage

// ===== hw/rtl/hcbp_if.sv =====
interface hcbp_in_if import hcbp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [SYM_W-1:0]   symbol;
  logic [CODE_W-1:0]  code_bits;
  logic [LEN_W-1:0]   code_length;

  modport source (output valid, command, symbol, code_bits, code_length, input ready);
  modport sink (input valid, command, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_out_if import hcbp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               is_final;
  logic [VBITS_W-1:0] valid_bits;
  logic [TOTAL_W-1:0] full_byte_total;
  logic               last;

  modport source (output valid, out_byte, is_final, valid_bits, full_byte_total, last,
                  input ready);
  modport sink (input valid, out_byte, is_final, valid_bits, full_byte_total, last,
                output ready);
endinterface

// ===== hw/rtl/hcbp_ram.sv =====
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/hcbp_packer.sv =====
module hcbp_packer import hcbp_pkg::*; #(
  parameter int LEN_LIMIT = MAX_CODE_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  hcbp_out_if.source  results
);

  localparam int AccW  = LEN_LIMIT + BYTE_W - 1;
  localparam int PendW = $clog2(AccW + 1);
  localparam logic [PendW-1:0] Byte = PendW'(BYTE_W);

  logic [AccW-1:0]    acc;
  logic [PendW-1:0]   pend;
  logic [TOTAL_W-1:0] cnt;

  logic               out_free;
  logic               has_byte;
  logic               emit;
  logic [PendW-1:0]   pend_after;
  logic               take;
  logic [BYTE_W-1:0]  byte_sel;
  logic [BYTE_W-1:0]  tail_mask;
  logic [TOTAL_W-1:0] cnt_inc;

  assign out_free   = !results.valid || results.ready;
  assign has_byte   = pend >= Byte;
  assign emit       = has_byte && out_free;
  assign pend_after = emit ? pend - Byte : pend;

  // a code can be absorbed in the cycle the previous code's last byte leaves
  assign item_ready = (pend_after < Byte) && (!item.flush || (!has_byte && out_free));
  assign take       = item_valid && item_ready;

  assign byte_sel  = BYTE_W'(acc >> (pend - Byte));
  assign tail_mask = (BYTE_W'(1) << pend[2:0]) - 1'b1;
  assign cnt_inc   = (cnt == '1) ? cnt : cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      pend          <= '0;
      cnt           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (take && item.flush) begin
        acc  <= '0;
        pend <= '0;
        cnt  <= '0;
      end else if (take) begin
        acc  <= (acc << item.len) | AccW'(item.code);
        pend <= pend_after + PendW'(item.len);
        if (emit) begin
          cnt <= cnt_inc;
        end
      end else begin
        pend <= pend_after;
        if (emit) begin
          cnt <= cnt_inc;
        end
      end

      if (emit) begin
        results.valid           <= 1'b1;
        results.out_byte        <= byte_sel;
        results.is_final        <= 1'b0;
        results.valid_bits      <= VBITS_W'(BYTE_W);
        results.full_byte_total <= cnt_inc;
        results.last            <= pend_after < Byte;
      end else if (take && item.flush) begin
        results.valid           <= 1'b1;
        results.out_byte        <= acc[BYTE_W-1:0] & tail_mask;
        results.is_final        <= 1'b1;
        results.valid_bits      <= VBITS_W'(pend);
        results.full_byte_total <= cnt;
        results.last            <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    int'(pend) <= AccW)
    else $error("pending bit count beyond accumulator");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    take && item.flush |=> pend == '0 && cnt == '0)
    else $error("flush did not clear packer state");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(emit && take && item.flush))
    else $error("flush taken while a full byte is leaving");

  a_final_short: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.is_final |-> results.valid_bits < VBITS_W'(BYTE_W))
    else $error("flush word carries a full byte");
`endif

endmodule

// ===== hw/rtl/huffman_code_bit_packer_top.sv =====
// A flush word passes the stage-1 register and the packer's output register; the first
// byte of an encode passes the table read, the accumulator and the output register, and
// further bytes follow one per cycle while the receiver is ready. Throughput: one item
// per cycle; an encode holds the packer until its bytes leave the single byte output port.
// Reset clears the accumulator, bit count and byte counter; the code table is not cleared.
module huffman_code_bit_packer_top import hcbp_pkg::*; #(
  parameter int SYMBOL_COUNT    = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hcbp_in_if.sink    items,
  hcbp_out_if.source results
);

  localparam int LenLimit = (MAX_CODE_LENGTH < CODE_W) ? MAX_CODE_LENGTH : CODE_W;
  localparam int AddrW    = $clog2(SYMBOL_COUNT);
  localparam int TblW     = LenLimit + LEN_W;

  logic              accept;
  logic              in_range;
  logic [AddrW-1:0]  addr;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W:0]   len_mask;
  logic [CODE_W-1:0] code_masked;
  logic              wr_en;
  logic              rd_en;
  logic [TblW-1:0]   rd_data;

  logic              s1_valid;
  logic              s1_flush;
  logic              pk_ready;
  item_t             pk_item;

  assign accept   = items.valid && items.ready;
  assign in_range = int'(items.symbol) < SYMBOL_COUNT;
  assign addr     = AddrW'(items.symbol);

  assign len_sat     = (int'(items.code_length) > LenLimit) ? LEN_W'(LenLimit)
                                                            : items.code_length;
  assign len_mask    = ((CODE_W+1)'(1) << len_sat) - 1'b1;
  assign code_masked = items.code_bits & len_mask[CODE_W-1:0];

  assign wr_en = accept && items.command == CMD_LOAD && in_range;
  assign rd_en = accept && items.command == CMD_ENCODE && in_range;

  hcbp_ram #(
    .WIDTH (TblW),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data ({len_sat, code_masked[LenLimit-1:0]}),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // loads finish in the table; only encodes and flushes move on
  assign items.ready = !s1_valid || pk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= rd_en || (accept && items.command == CMD_FLUSH);
      s1_flush <= items.command == CMD_FLUSH;
    end
  end

  assign pk_item.flush = s1_flush;
  assign pk_item.code  = CODE_W'(rd_data[LenLimit-1:0]);
  assign pk_item.len   = rd_data[TblW-1:LenLimit];

  hcbp_packer #(
    .LEN_LIMIT (LenLimit)
  ) u_packer (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s1_valid),
    .item_ready (pk_ready),
    .item       (pk_item),
    .results    (results)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hcbp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int LEN_CAP = (MAX_CODE_LENGTH_DEF < 32) ? MAX_CODE_LENGTH_DEF : 32;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               fin;
    logic [VBITS_W-1:0] nbits;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } byte_exp_t;

  logic clk = 1'b0;
  logic rst;

  hcbp_in_if  items_if ();
  hcbp_out_if results_if ();

  huffman_code_bit_packer_top u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  // stimulus side
  in_word_t send_q[$];
  in_word_t drv_word;
  int       words_queued = 0;
  bit       gen_loaded[SYMBOL_COUNT_DEF];
  int       gen_syms[$];
  int       in_idle_pct = 33;
  int       out_idle_pct = 57;

  // output hold-off
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  // packer prediction state
  logic [CODE_W-1:0] tbl_code[SYMBOL_COUNT_DEF];
  logic [LEN_W-1:0]  tbl_len[SYMBOL_COUNT_DEF];
  logic [38:0]       acc = '0;
  int                acc_bits = 0;
  logic [TOTAL_W-1:0] full_bytes = '0;
  byte_exp_t         bytes_due[$];
  byte_exp_t         due_word;

  int errors = 0;
  int words_taken = 0;
  int bytes_seen = 0;
  int flush_seen = 0;

  task automatic note_mismatch(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic pack_word(input in_word_t w);
    logic [LEN_W-1:0]  n;
    byte_exp_t         e;
    case (w.cmd)
      CMD_LOAD: begin
        n = (w.len > LEN_CAP) ? LEN_W'(LEN_CAP) : w.len;
        tbl_code[w.sym] = CODE_W'(w.code & ((33'd1 << n) - 33'd1));
        tbl_len[w.sym] = n;
      end
      CMD_ENCODE: begin
        acc = (acc << tbl_len[w.sym]) | 39'(tbl_code[w.sym]);
        acc_bits += tbl_len[w.sym];
        while (acc_bits >= 8) begin
          acc_bits -= 8;
          if (full_bytes != '1) full_bytes++;
          e.data = 8'(acc >> acc_bits);
          e.fin = 1'b0;
          e.nbits = 4'd8;
          e.total = full_bytes;
          e.last = (acc_bits < 8);
          bytes_due = {bytes_due, e};
        end
        acc = acc & ((39'd1 << acc_bits) - 39'd1);
      end
      CMD_FLUSH: begin
        e.data = 8'(acc);
        e.fin = 1'b1;
        e.nbits = 4'(acc_bits);
        e.total = full_bytes;
        e.last = 1'b1;
        bytes_due = {bytes_due, e};
        acc = '0;
        acc_bits = 0;
        full_bytes = '0;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
    end else if (!items_if.valid || items_if.ready) begin
      if (send_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        drv_word = send_q.pop_front();
        items_if.valid <= 1'b1;
        items_if.command <= drv_word.cmd;
        items_if.symbol <= drv_word.sym;
        items_if.code_bits <= drv_word.code;
        items_if.code_length <= drv_word.len;
      end else begin
        items_if.valid <= 1'b0;
      end
    end
  end

  // long receiver stall, armed once by the stimulus
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // monitor: check outgoing words, then predict from the accepted input word
  always @(posedge clk) begin
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        bytes_seen++;
        if (results_if.is_final) flush_seen++;
        if (bytes_due.size() == 0) begin
          note_mismatch($sformatf("unexpected word byte=%02h final=%0b",
                                  results_if.out_byte, results_if.is_final));
        end else begin
          due_word = bytes_due.pop_front();
          if (results_if.out_byte !== due_word.data)
            note_mismatch($sformatf("out_byte %02h, want %02h",
                                    results_if.out_byte, due_word.data));
          if (results_if.is_final !== due_word.fin)
            note_mismatch($sformatf("is_final %0b, want %0b",
                                    results_if.is_final, due_word.fin));
          if (results_if.valid_bits !== due_word.nbits)
            note_mismatch($sformatf("valid_bits %0d, want %0d",
                                    results_if.valid_bits, due_word.nbits));
          if (results_if.full_byte_total !== due_word.total)
            note_mismatch($sformatf("full_byte_total %0d, want %0d",
                                    results_if.full_byte_total, due_word.total));
          if (results_if.last !== due_word.last)
            note_mismatch($sformatf("last %0b, want %0b",
                                    results_if.last, due_word.last));
        end
      end
      if (items_if.valid && items_if.ready) begin
        words_taken++;
        pack_word('{items_if.command, items_if.symbol, items_if.code_bits,
                    items_if.code_length});
      end
    end
  end

  task automatic queue_word(input logic [CMD_W-1:0] cmd, input int sym,
                            input logic [CODE_W-1:0] code, input int len);
    in_word_t w;
    w = '{cmd, SYM_W'(sym), code, LEN_W'(len)};
    send_q = {send_q, w};
    words_queued++;
    if (cmd == CMD_LOAD && !gen_loaded[sym]) begin
      gen_loaded[sym] = 1'b1;
      gen_syms = {gen_syms, sym};
    end
  endtask

  task automatic queue_random(input int count);
    int r;
    int sel;
    int len;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 20 || gen_syms.size() == 0) begin
        sel = $urandom_range(9);
        if (sel == 0) len = 0;
        else if (sel == 1) len = $urandom_range(63, 33);
        else if (sel == 2) len = $urandom_range(32, 17);
        else len = $urandom_range(16, 1);
        queue_word(CMD_LOAD, $urandom_range(SYMBOL_COUNT_DEF - 1), $urandom, len);
      end else if (r < 85) begin
        // encode ignores code_bits/code_length, so fill them with junk
        queue_word(CMD_ENCODE, gen_syms[$urandom_range(gen_syms.size() - 1)],
                   $urandom, $urandom_range(63));
      end else if (r < 95) begin
        queue_word(CMD_FLUSH, $urandom_range(127), $urandom, $urandom_range(63));
      end else begin
        queue_word(CMD_UNUSED, $urandom_range(127), $urandom, $urandom_range(63));
      end
    end
  endtask

  task automatic drain_input();
    while (words_taken < words_queued) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.command = CMD_LOAD;
    items_if.symbol = '0;
    items_if.code_bits = '0;
    items_if.code_length = '0;
    results_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: table extremes, saturation, masking, empty flush, ignored command
    queue_word(CMD_LOAD, 0, 32'hFFFF_FFFF, 0);
    queue_word(CMD_LOAD, 127, 32'hFFFF_FFFF, 32);
    queue_word(CMD_LOAD, 1, 32'hA5A5_5A5A, 63);
    queue_word(CMD_LOAD, 2, 32'h0000_0001, 1);
    queue_word(CMD_LOAD, 3, 32'hFFFF_FFD5, 7);
    queue_word(CMD_LOAD, 4, 32'h8000_0001, 33);
    queue_word(CMD_LOAD, 5, 32'h0000_0000, 32);
    queue_word(CMD_FLUSH, 0, 32'h0, 0);
    queue_word(CMD_ENCODE, 0, 32'hFFFF_FFFF, 63);
    queue_word(CMD_ENCODE, 2, 32'h0, 0);
    queue_word(CMD_ENCODE, 3, 32'h0, 0);
    queue_word(CMD_ENCODE, 127, 32'h0, 0);
    queue_word(CMD_ENCODE, 1, 32'h0, 0);
    queue_word(CMD_UNUSED, 127, 32'hFFFF_FFFF, 63);
    queue_word(CMD_ENCODE, 2, 32'h0, 0);
    queue_word(CMD_FLUSH, 127, 32'hFFFF_FFFF, 63);
    queue_word(CMD_ENCODE, 127, 32'h0, 0);
    queue_word(CMD_ENCODE, 5, 32'h0, 0);
    queue_word(CMD_ENCODE, 4, 32'h0, 0);
    queue_word(CMD_FLUSH, 0, 32'h0, 0);
    queue_word(CMD_LOAD, 127, 32'h0000_0155, 9);
    queue_word(CMD_ENCODE, 127, 32'h0, 0);
    queue_word(CMD_FLUSH, 0, 32'h0, 0);
    drain_input();

    queue_random(160);
    drain_input();

    in_idle_pct = 57;
    out_idle_pct = 33;
    queue_random(160);
    drain_input();

    // back-pressure: receiver stalls while 32-bit codes keep arriving
    in_idle_pct = 0;
    out_idle_pct = 0;
    queue_word(CMD_LOAD, 126, $urandom, 32);
    drain_input();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) queue_word(CMD_ENCODE, 126, $urandom, $urandom_range(63));
    queue_word(CMD_FLUSH, 0, 32'h0, 0);
    drain_input();

    queue_random(120);
    drain_input();
    while (bytes_due.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (bytes_due.size() != 0)
      note_mismatch($sformatf("%0d words never arrived", bytes_due.size()));

    $display("run covered %0d input words (loads, encodes, flushes, unused command)",
             words_taken);
    $display("checked %0d output words, %0d of them flush words", bytes_seen, flush_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d of %0d input words taken, %0d words pending",
             words_taken, words_queued, bytes_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
